// ===== hdl/periodic_task_tick_scheduler_macros.svh =====
// Assertion shorthands used by the checker of the tick scheduler.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define PTTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptts checker: same-cycle implication violated");

// Next-cycle implication, masked while reset is held.
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptts checker: next-cycle implication violated");

// What must hold in the cycle after a reset edge.
`define PTTS_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("ptts checker: post-reset condition violated");

`endif

// ===== hdl/ptts_pkg.sv =====
`default_nettype none

package ptts_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int TICK_MS     = 1;

  localparam int SLOT_ARRAY  = 8;
  localparam int SLOT_W      = 3;
  localparam int PERIOD_W    = 16;
  localparam int SLEEP_W     = 32;
  localparam int CMD_W       = 2;
  localparam int STATE_W     = 2;
  localparam int MASK_W      = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLEEP   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd3;

  // Slot states
  localparam logic [STATE_W-1:0] ST_READY     = 2'd0;
  localparam logic [STATE_W-1:0] ST_SLEEPING  = 2'd1;
  localparam logic [STATE_W-1:0] ST_SUSPENDED = 2'd2;

  // ceil(2^32 / TICK_MS): exact quotient for any 16-bit period, TICK_MS up to 1000
  localparam longint RECIP_L  = ((64'sd1 <<< 32) + longint'(TICK_MS) - 64'sd1)
                                / longint'(TICK_MS);
  localparam int     RECIP_W  = 33;
  localparam int     PROD_W   = PERIOD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] TICK_RECIP = RECIP_W'(RECIP_L);

  typedef logic [SLOT_ARRAY-1:0][PERIOD_W-1:0] period_arr_t;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [SLOT_W-1:0]  slot;
    logic               slot_in_range;
    logic [SLEEP_W-1:0] sleep_time;
  } job_t;

  // period / TICK_MS through the reciprocal
  function automatic logic [PERIOD_W-1:0] load_value(input logic [PERIOD_W-1:0] period);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(period) * PROD_W'(TICK_RECIP);
    return prod[32 +: PERIOD_W];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ptts_front.sv =====
`default_nettype none

module ptts_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ptts_pkg::CMD_W-1:0]    in_command,
  input  wire logic [ptts_pkg::SLOT_W-1:0]   in_task_slot,
  input  wire logic [ptts_pkg::SLEEP_W-1:0]  in_sleep_time_ms,
  output logic                               push_valid,
  output ptts_pkg::job_t                     push_job,
  input  wire logic                          queue_full
);

  logic           front_valid_r, front_valid_nxt;
  ptts_pkg::job_t job_r, job_nxt;
  logic           accept;
  logic           addr_ok;

  assign in_stall   = front_valid_r && queue_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = front_valid_r;
  assign push_job   = job_r;

  // only suspend and sleep address a slot
  always_comb begin
    case (in_command) inside
      ptts_pkg::CMD_SUSPEND, ptts_pkg::CMD_SLEEP: begin
        addr_ok = ({1'b0, in_task_slot} < (ptts_pkg::SLOT_W + 1)'(ptts_pkg::NUM_SLOTS));
      end
      default: begin
        addr_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    front_valid_nxt = (front_valid_r && queue_full) || accept;
    job_nxt         = job_r;
    if (accept) begin
      job_nxt.op            = in_command;
      job_nxt.slot          = in_task_slot;
      job_nxt.slot_in_range = addr_ok;
      job_nxt.sleep_time    = in_sleep_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    job_r <= job_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/ptts_queue.sv =====
`default_nettype none

module ptts_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  wire ptts_pkg::job_t push_job,
  output logic                full,
  output logic                pop_valid,
  output ptts_pkg::job_t      pop_job,
  input  wire logic           pop
);

  ptts_pkg::job_t                  mem_r [ptts_pkg::QUEUE_DEPTH];
  logic [ptts_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ptts_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ptts_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  localparam logic [ptts_pkg::QPTR_W-1:0] PTR_LAST = ptts_pkg::QPTR_W'(ptts_pkg::QUEUE_DEPTH - 1);
  localparam logic [ptts_pkg::QCNT_W-1:0] CNT_FULL = ptts_pkg::QCNT_W'(ptts_pkg::QUEUE_DEPTH);

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : ptts_pkg::QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : ptts_pkg::QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = ptts_pkg::QCNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = ptts_pkg::QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ptts_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ptts_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ptts_pkg::SLEEP_W-1:0]  dividend,
  input  wire logic [ptts_pkg::PERIOD_W-1:0] divisor,
  output logic                               done,
  output logic [ptts_pkg::SLEEP_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(ptts_pkg::SLEEP_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ptts_pkg::SLEEP_W - 1);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [ptts_pkg::PERIOD_W-1:0]     rem_r, rem_nxt;
  logic [ptts_pkg::SLEEP_W-1:0]      quo_r, quo_nxt;
  logic [ptts_pkg::PERIOD_W-1:0]     dsr_r, dsr_nxt;
  logic [ptts_pkg::PERIOD_W:0]       trial;
  logic                              qbit;

  assign done     = done_r;
  assign quotient = quo_r;

  assign trial = {rem_r, quo_r[ptts_pkg::SLEEP_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? ptts_pkg::PERIOD_W'(trial - {1'b0, dsr_r})
                     : ptts_pkg::PERIOD_W'(trial);
      quo_nxt = {quo_r[ptts_pkg::SLEEP_W-2:0], qbit};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/ptts_back.sv =====
`default_nettype none

module ptts_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ptts_pkg::period_arr_t         period,
  input  wire logic                          job_valid,
  input  wire ptts_pkg::job_t                job,
  output logic                               job_pop,
  output logic                               div_start,
  output logic [ptts_pkg::SLEEP_W-1:0]       div_dividend,
  output logic [ptts_pkg::PERIOD_W-1:0]      div_divisor,
  input  wire logic                          div_done,
  input  wire logic [ptts_pkg::SLEEP_W-1:0]  div_quotient,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ptts_pkg::MASK_W-1:0]        out_run_mask,
  output logic                               out_status
);

  localparam int BS_W = 2;
  localparam logic [BS_W-1:0] B_IDLE = 2'd0;
  localparam logic [BS_W-1:0] B_WALK = 2'd1;
  localparam logic [BS_W-1:0] B_CMD  = 2'd2;
  localparam logic [BS_W-1:0] B_DIV  = 2'd3;

  logic [BS_W-1:0]                   bstate_r, bstate_nxt;
  ptts_pkg::job_t                    job_r, job_nxt;
  logic [ptts_pkg::SLOT_W-1:0]       cur_r, cur_nxt;
  logic [ptts_pkg::MASK_W-1:0]       mask_r, mask_nxt;

  logic [ptts_pkg::PERIOD_W-1:0]     countdown_r   [ptts_pkg::SLOT_ARRAY];
  logic [ptts_pkg::STATE_W-1:0]      slot_state_r  [ptts_pkg::SLOT_ARRAY];
  logic [ptts_pkg::SLEEP_W-1:0]      sleep_count_r [ptts_pkg::SLOT_ARRAY];

  logic                              cd_we, st_we, sc_we;
  logic [ptts_pkg::PERIOD_W-1:0]     cd_wd;
  logic [ptts_pkg::STATE_W-1:0]      st_wd;
  logic [ptts_pkg::SLEEP_W-1:0]      sc_wd;

  logic                              out_valid_r, out_valid_nxt;
  logic [ptts_pkg::MASK_W-1:0]       out_mask_r, out_mask_nxt;
  logic                              out_status_r, out_status_nxt;

  logic [ptts_pkg::PERIOD_W-1:0]     per, cd, lv, reload;
  logic [ptts_pkg::STATE_W-1:0]      st;
  logic [ptts_pkg::SLEEP_W-1:0]      sc, sc_dec;
  logic                              present;
  logic [ptts_pkg::MASK_W-1:0]       cur_bit;

  assign out_valid    = out_valid_r;
  assign out_run_mask = out_mask_r;
  assign out_status   = out_status_r;

  assign div_dividend = job_r.sleep_time;
  assign div_divisor  = per;

  assign per     = period[cur_r];
  assign cd      = countdown_r[cur_r];
  assign st      = slot_state_r[cur_r];
  assign sc      = sleep_count_r[cur_r];
  assign lv      = ptts_pkg::load_value(per);
  assign reload  = (lv == '0) ? '0 : ptts_pkg::PERIOD_W'(lv - 1'b1);
  assign sc_dec  = (sc == '0) ? '0 : ptts_pkg::SLEEP_W'(sc - 1'b1);
  assign present = job_r.slot_in_range && (per != '0);
  assign cur_bit = ptts_pkg::MASK_W'(1) << cur_r;

  always_comb begin
    bstate_nxt     = bstate_r;
    job_nxt        = job_r;
    cur_nxt        = cur_r;
    mask_nxt       = mask_r;
    job_pop        = 1'b0;
    div_start      = 1'b0;
    cd_we          = 1'b0;
    cd_wd          = reload;
    st_we          = 1'b0;
    st_wd          = ptts_pkg::ST_READY;
    sc_we          = 1'b0;
    sc_wd          = sc_dec;
    out_valid_nxt  = out_valid_r && out_stall;
    out_mask_nxt   = out_mask_r;
    out_status_nxt = out_status_r;

    unique case (bstate_r)
      B_IDLE: begin
        // the result register is free for the whole job once it is taken here
        if (job_valid && !out_valid_r) begin
          job_pop  = 1'b1;
          job_nxt  = job;
          mask_nxt = '0;
          unique case (job.op) inside
            ptts_pkg::CMD_TICK, ptts_pkg::CMD_START: begin
              cur_nxt    = '0;
              bstate_nxt = B_WALK;
            end
            default: begin
              cur_nxt    = job.slot;
              bstate_nxt = B_CMD;
            end
          endcase
        end
      end

      B_WALK: begin
        if (job_r.op == ptts_pkg::CMD_START) begin
          cd_we = 1'b1;
          cd_wd = lv;
          st_we = 1'b1;
          st_wd = ptts_pkg::ST_READY;
        end else begin
          cd_we = 1'b1;
          if (cd == '0) begin
            cd_wd = reload;
            if (st == ptts_pkg::ST_READY) begin
              if (per != '0) begin
                mask_nxt = mask_r | cur_bit;
              end
            end else if (st == ptts_pkg::ST_SLEEPING) begin
              sc_we = 1'b1;
              if (sc_dec == '0) begin
                st_we = 1'b1;
                st_wd = ptts_pkg::ST_READY;
              end
            end
          end else begin
            cd_wd = ptts_pkg::PERIOD_W'(cd - 1'b1);
          end
        end
        if (cur_r == ptts_pkg::LAST_SLOT) begin
          out_valid_nxt  = 1'b1;
          out_mask_nxt   = mask_nxt;
          out_status_nxt = 1'b0;
          bstate_nxt     = B_IDLE;
        end else begin
          cur_nxt = ptts_pkg::SLOT_W'(cur_r + 1'b1);
        end
      end

      B_CMD: begin
        out_mask_nxt = '0;
        if (job_r.op == ptts_pkg::CMD_SUSPEND) begin
          if (present) begin
            st_we = 1'b1;
            st_wd = ptts_pkg::ST_SUSPENDED;
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = !present;
          bstate_nxt     = B_IDLE;
        end else if (present && (st == ptts_pkg::ST_READY)
                     && (job_r.sleep_time > ptts_pkg::SLEEP_W'(per))) begin
          div_start  = 1'b1;
          bstate_nxt = B_DIV;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          bstate_nxt     = B_IDLE;
        end
      end

      B_DIV: begin
        if (div_done) begin
          sc_we          = 1'b1;
          sc_wd          = div_quotient;
          st_we          = 1'b1;
          st_wd          = ptts_pkg::ST_SLEEPING;
          out_valid_nxt  = 1'b1;
          out_mask_nxt   = '0;
          out_status_nxt = 1'b0;
          bstate_nxt     = B_IDLE;
        end
      end

      default: begin
        bstate_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ptts_pkg::SLOT_ARRAY; i++) begin
        countdown_r[i]   <= '0;
        slot_state_r[i]  <= ptts_pkg::ST_READY;
        sleep_count_r[i] <= '0;
      end
    end else begin
      bstate_r    <= bstate_nxt;
      out_valid_r <= out_valid_nxt;
      if (cd_we) begin
        countdown_r[cur_r] <= cd_wd;
      end
      if (st_we) begin
        slot_state_r[cur_r] <= st_wd;
      end
      if (sc_we) begin
        sleep_count_r[cur_r] <= sc_wd;
      end
    end
    job_r        <= job_nxt;
    cur_r        <= cur_nxt;
    mask_r       <= mask_nxt;
    out_mask_r   <= out_mask_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/periodic_task_tick_scheduler.sv =====
// Path, accepted input to result valid: front register, job queue, then the back end; tick and
// start walk the slots (one slot per cycle), suspend or a refused sleep ends in the command state.
// An accepted sleep also waits on the serial divider. The back end works on one transaction at a
// time and takes the next only once its result register is empty; the front and queue hold the rest.
// Reset (rst_n, synchronous): periods 0, countdowns and sleep counts 0, all slots
// ready, queue and result register empty.
`default_nettype none

module periodic_task_tick_scheduler (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ptts_pkg::CMD_W-1:0]       in_command,
  input  wire logic [ptts_pkg::SLOT_W-1:0]      in_task_slot,
  input  wire logic [ptts_pkg::SLEEP_W-1:0]     in_sleep_time_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ptts_pkg::MASK_W-1:0]           out_run_mask,
  output logic                                  out_status,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ptts_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [ptts_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ptts_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  ptts_pkg::period_arr_t            period_r;
  logic [ptts_pkg::SLOT_W-1:0]      reg_idx;
  logic                             cfg_wr;

  logic                             push_valid, queue_full;
  ptts_pkg::job_t                   push_job, pop_job;
  logic                             pop_valid, pop;

  logic                             div_start, div_done;
  logic [ptts_pkg::SLEEP_W-1:0]     div_dividend, div_quotient;
  logic [ptts_pkg::PERIOD_W-1:0]    div_divisor;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ptts_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = ptts_pkg::CFG_DATA_W'(period_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
    end else if (cfg_wr) begin
      period_r[reg_idx] <= pwdata[ptts_pkg::PERIOD_W-1:0];
    end
  end

  ptts_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_task_slot     (in_task_slot),
    .in_sleep_time_ms (in_sleep_time_ms),
    .push_valid       (push_valid),
    .push_job         (push_job),
    .queue_full       (queue_full)
  );

  ptts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop        (pop)
  );

  ptts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .period       (period_r),
    .job_valid    (pop_valid),
    .job          (pop_job),
    .job_pop      (pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_run_mask (out_run_mask),
    .out_status   (out_status)
  );

  ptts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

// ===== hdl/ptts_checker.sv =====
`default_nettype none

`include "periodic_task_tick_scheduler_macros.svh"

module ptts_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_stall,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire logic [ptts_pkg::MASK_W-1:0]      out_run_mask,
  input  wire logic                             out_status
);

  // a stalled result keeps its payload
  `PTTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({out_run_mask, out_status}))

  // a refusal never comes with fired tasks
  `PTTS_ASSERT_IMPL(a_refuse_no_fire, out_valid && out_status, out_run_mask == '0)

  // no slot beyond the configured count ever fires
  `PTTS_ASSERT_IMPL(a_fire_in_range, out_valid, (16'(out_run_mask) >> ptts_pkg::NUM_SLOTS) == 16'd0)

  // reset empties the result register and the input stage
  `PTTS_ASSERT_RST(a_rst_empty, !out_valid && !in_stall)

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

`default_nettype wire

// ===== tb/sv/ptts_schedule_checker.sv =====
`timescale 1ns / 1ps

module ptts_schedule_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [ptts_pkg::CMD_W-1:0]      in_command,
  input  logic [ptts_pkg::SLOT_W-1:0]     in_task_slot,
  input  logic [ptts_pkg::SLEEP_W-1:0]    in_sleep_time_ms,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ptts_pkg::MASK_W-1:0]     out_run_mask,
  input  logic                            out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ptts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ptts_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              fail_count,
  output int                              pending
);
  import ptts_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] run_mask;
    logic              status;
  } slot_report_t;

  localparam logic [31:0] TICK = TICK_MS;

  logic [PERIOD_W-1:0] period_ms   [SLOT_ARRAY];
  logic [PERIOD_W-1:0] countdown   [SLOT_ARRAY];
  logic [STATE_W-1:0]  mode        [SLOT_ARRAY];
  logic [SLEEP_W-1:0]  sleeps_left [SLOT_ARRAY];
  slot_report_t        reports_due [$];
  int                  errors = 0;

  function automatic logic [PERIOD_W-1:0] reload_of(int s);
    return PERIOD_W'(32'(period_ms[s]) / TICK);
  endfunction

  function automatic logic slot_live(logic [SLOT_W-1:0] s);
    return (int'(s) < NUM_SLOTS) && (period_ms[s] != '0);
  endfunction

  // Advances the slot table by one transaction and returns what the block should report
  function automatic slot_report_t schedule_step(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] s,
                                                 logic [SLEEP_W-1:0] stime);
    slot_report_t        r;
    logic [PERIOD_W-1:0] lv;
    r = '0;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (countdown[i] == '0) begin
            if (mode[i] == ST_READY) begin
              if (period_ms[i] != '0) r.run_mask[i] = 1'b1;
            end else if (mode[i] == ST_SLEEPING) begin
              if (sleeps_left[i] != '0) sleeps_left[i] = sleeps_left[i] - 32'd1;
              if (sleeps_left[i] == '0) mode[i] = ST_READY;
            end
            lv = reload_of(i);
            countdown[i] = (lv == '0) ? '0 : lv - 16'd1;
          end else begin
            countdown[i] = countdown[i] - 16'd1;
          end
        end
      end
      CMD_SUSPEND: begin
        if (slot_live(s)) mode[s] = ST_SUSPENDED;
        else r.status = 1'b1;
      end
      CMD_SLEEP: begin
        if (slot_live(s) && mode[s] == ST_READY && stime > 32'(period_ms[s])) begin
          mode[s] = ST_SLEEPING;
          sleeps_left[s] = stime / 32'(period_ms[s]);
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        // start: sleep counts are left alone
        for (int i = 0; i < NUM_SLOTS; i++) begin
          countdown[i] = reload_of(i);
          mode[i] = ST_READY;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    slot_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_ARRAY; i++) begin
        period_ms[i] = '0;
        countdown[i] = '0;
        mode[i] = ST_READY;
        sleeps_left[i] = '0;
      end
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result: run_mask %h status %0d", $time,
                     out_run_mask, out_status);
        end else begin
          want = reports_due.pop_front();
          if (want.run_mask !== out_run_mask || want.status !== out_status) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch: expected run_mask %h status %0d, got run_mask %h status %0d",
                       $time, want.run_mask, want.status, out_run_mask, out_status);
          end
        end
      end
      if (in_valid && !in_stall)
        reports_due.push_back(schedule_step(in_command, in_task_slot, in_sleep_time_ms));
      if (psel && penable && pwrite && pready)
        period_ms[paddr[CFG_ADDR_W-1:2]] = pwdata[PERIOD_W-1:0];
    end
    fail_count <= errors;
    pending <= reports_due.size();
  end

endmodule

// ===== tb/sv/periodic_task_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;
  import ptts_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int STALL_LIMIT     = 5000;
  localparam int LONG_HOLD       = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command;
  logic [SLOT_W-1:0]     in_task_slot;
  logic [SLEEP_W-1:0]    in_sleep_time_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [MASK_W-1:0]     out_run_mask;
  logic                  out_status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  logic [PERIOD_W-1:0]   periods_set [SLOT_ARRAY];
  int                    burst_left;
  int                    idle_cycles;

  periodic_task_tick_scheduler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_task_slot    (in_task_slot),
    .in_sleep_time_ms(in_sleep_time_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_run_mask    (out_run_mask),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  ptts_schedule_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_task_slot    (in_task_slot),
    .in_sleep_time_ms(in_sleep_time_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_run_mask    (out_run_mask),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic write_period(input int slot, input logic [PERIOD_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(slot * 4);
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    periods_set[slot] = value;
  endtask

  // pending is registered, so step the clock before looking at it
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One transaction; valid stays up inside a burst and drops for the gap after it
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                       input logic [SLEEP_W-1:0] stime);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_task_slot <= slot;
    in_sleep_time_ms <= stime;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_item();
    int                  pick;
    logic [SLOT_W-1:0]   s;
    logic [SLEEP_W-1:0]  stime;
    logic [31:0]         p;
    pick = $urandom_range(0, 99);
    s = SLOT_W'($urandom_range(0, SLOT_ARRAY - 1));
    stime = $urandom;
    p = 32'(periods_set[s]);
    if (pick < 62) begin
      offer(CMD_TICK, s, stime);
    end else if (pick < 70) begin
      offer(CMD_SUSPEND, s, stime);
    end else if (pick < 94) begin
      case ($urandom_range(0, 5))
        0: stime = $urandom;
        1: stime = p;
        2: stime = $urandom_range(0, p);
        default: stime = p * $urandom_range(1, 6) + $urandom_range(0, p);
      endcase
      offer(CMD_SLEEP, s, stime);
    end else begin
      offer(CMD_START, s, stime);
    end
  endtask

  // Receiver: free runs, random stalls, solid stalls, and now and then a long hold-off
  initial begin
    int segment;
    int len;
    int kind;
    out_stall = 1'b0;
    segment = 0;
    forever begin
      segment++;
      if (segment % 150 == 20) begin
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        kind = $urandom_range(0, 9);
        len = $urandom_range(1, 40);
        repeat (len) begin
          @(posedge clk);
          if (kind < 4) out_stall <= 1'b0;
          else if (kind < 8) out_stall <= ($urandom_range(0, 2) == 0);
          else out_stall <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("periodic_task_tick_scheduler verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_TICK;
    in_task_slot = '0;
    in_sleep_time_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 1;
    for (int i = 0; i < SLOT_ARRAY; i++) periods_set[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // all slots empty straight out of reset
    offer(CMD_TICK, 3'd7, 32'd0);
    in_valid <= 1'b0;
    wait_idle();
    write_period(0, 16'd1);
    write_period(1, 16'd2);
    write_period(2, 16'd3);
    write_period(3, 16'd0);
    write_period(4, 16'hFFFF);
    write_period(5, 16'd5);
    write_period(6, 16'd4);
    write_period(7, 16'd7);

    // slots are ready with zero countdowns before any start
    offer(CMD_TICK, 3'd0, 32'hFFFF_FFFF);
    offer(CMD_TICK, 3'd3, 32'd0);
    offer(CMD_START, 3'd0, 32'd0);
    repeat (3) offer(CMD_TICK, 3'd0, 32'd0);
    offer(CMD_SUSPEND, 3'd3, 32'd0);
    offer(CMD_SUSPEND, 3'd2, 32'd0);
    offer(CMD_SLEEP, 3'd2, 32'd100);
    offer(CMD_SLEEP, 3'd0, 32'd1);
    offer(CMD_SLEEP, 3'd1, 32'hFFFF_FFFF);
    offer(CMD_SLEEP, 3'd5, 32'd11);
    offer(CMD_SLEEP, 3'd5, 32'd11);
    offer(CMD_SLEEP, 3'd3, 32'd100);
    offer(CMD_SUSPEND, 3'd4, 32'd0);
    repeat (6) offer(CMD_TICK, 3'd7, 32'd0);
    offer(CMD_START, 3'd7, 32'hFFFF_FFFF);
    offer(CMD_SLEEP, 3'd6, 32'd5);
    repeat (2) offer(CMD_TICK, 3'd0, 32'd0);
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      for (int i = 0; i < SLOT_ARRAY; i++) begin
        case (ph)
          1: write_period(i, 16'd1);
          3: write_period(i, 16'hFFFF);
          5: write_period(i, 16'd0);
          default: begin
            r = $urandom_range(0, 99);
            if (r < 10) write_period(i, 16'd0);
            else if (r < 80) write_period(i, PERIOD_W'($urandom_range(1, 8)));
            else if (r < 95) write_period(i, PERIOD_W'($urandom_range(9, 40)));
            else write_period(i, PERIOD_W'($urandom_range(0, 65535)));
          end
        endcase
      end
      if ($urandom_range(0, 4) != 0) offer(CMD_START, SLOT_W'($urandom_range(0, 7)), $urandom);
      repeat (ITEMS_PER_PHASE) random_item();
      in_valid <= 1'b0;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("periodic_task_tick_scheduler verification clean");
    end else begin
      $display("periodic_task_tick_scheduler verification failed");
    end
    $finish;
  end

endmodule
